>>> rtl/core/ocx_pkg.sv
`default_nettype none

package ocx_pkg;

    // Fixed field widths of the beats and of the register.
    localparam int GENE_W     = 6;
    localparam int CUT_S_W    = 6;
    localparam int CUT_E_W    = 7;
    localparam int CFG_W      = 7;
    localparam int MAP_DEPTH  = 2 ** GENE_W;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic             REG_GENE_COUNT   = 1'b0;
    localparam logic [CFG_W-1:0] GENE_COUNT_RESET = 7'd64;

    // One crossover job handed from the front to the back.
    typedef struct packed {
        logic               bad;
        logic [CUT_S_W-1:0] cut_start;
        logic [CUT_E_W-1:0] cut_end;
    } t_cmd;

    // Parent store write that goes with every accepted beat.
    typedef struct packed {
        logic              we;
        logic [GENE_W-1:0] first_gene;
        logic [GENE_W-1:0] second_gene;
    } t_store_wr;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEG_RD,
        BK_SEG_WR,
        BK_FILL_POS,
        BK_FILL_CHK,
        BK_OUT_RD,
        BK_OUT_SEND,
        BK_ERR
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/core/ocx_if.sv
`default_nettype none

// Gene pair channel into the block.
interface ocx_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic [ocx_pkg::GENE_W-1:0]           first_gene;
    logic [ocx_pkg::GENE_W-1:0]           second_gene;
    logic [ocx_pkg::CUT_S_W-1:0]          cut_start;
    logic [ocx_pkg::CUT_E_W-1:0]          cut_end;
    logic                                 last_pair;

    modport source (output valid, first_gene, second_gene, cut_start, cut_end, last_pair,
                    input ready);
    modport sink   (input valid, first_gene, second_gene, cut_start, cut_end, last_pair,
                    output ready);
endinterface

// Child gene channel out of the block.
interface ocx_child_if;
    logic                       valid;
    logic                       ready;
    logic [ocx_pkg::GENE_W-1:0] child_gene;
    logic                       bad_cuts;
    logic                       last_gene;

    modport source (output valid, child_gene, bad_cuts, last_gene, input ready);
    modport sink   (input valid, child_gene, bad_cuts, last_gene, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ocx_front.sv
`default_nettype none

module ocx_front #(
    parameter int MAX_GENES = 64,
    localparam int PW = $clog2(MAX_GENES),
    localparam int CW = $clog2(MAX_GENES + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [CW-1:0]   i_n_genes,
    input  wire logic            i_back_idle,
    input  wire logic            i_queue_empty,
    ocx_pair_if.sink             i_pair,
    output ocx_pkg::t_store_wr   o_wr,
    output logic [PW-1:0]        o_wr_addr,
    output logic                 o_push,
    output ocx_pkg::t_cmd        o_cmd
);

    localparam int WW = (CW > ocx_pkg::CUT_E_W) ? CW : ocx_pkg::CUT_E_W;

    logic [CW-1:0] r_load_pos;
    logic [CW-1:0] n_load_pos;
    logic          accept;
    logic          room;

    // Parent stores are only touched while the back is idle with nothing queued.
    assign i_pair.ready = i_back_idle && i_queue_empty;
    assign accept       = i_pair.valid && i_pair.ready;
    assign room         = r_load_pos < CW'(MAX_GENES);

    // Store write for every beat that still has a free position.
    assign o_wr.we          = accept && room;
    assign o_wr.first_gene  = i_pair.first_gene;
    assign o_wr.second_gene = i_pair.second_gene;
    assign o_wr_addr        = r_load_pos[PW-1:0];

    // The final pair starts a job; cut checks are settled here.
    assign o_push          = accept && i_pair.last_pair;
    assign o_cmd.cut_start = i_pair.cut_start;
    assign o_cmd.cut_end   = i_pair.cut_end;
    assign o_cmd.bad       = ({1'b0, i_pair.cut_start} >= i_pair.cut_end) ||
                             (WW'(i_pair.cut_end) > WW'(i_n_genes));

    // Load position counts up, saturates, and restarts after the final pair.
    always_comb begin
        n_load_pos = r_load_pos;
        if (accept) begin
            if (i_pair.last_pair) begin
                n_load_pos = '0;
            end else if (room) begin
                n_load_pos = r_load_pos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
        end else begin
            r_load_pos <= n_load_pos;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ocx_cmd_queue.sv
`default_nettype none

module ocx_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ocx_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic               o_empty,
    output ocx_pkg::t_cmd      o_cmd
);

    ocx_pkg::t_cmd r_entry [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_valid = r_count != 2'd0;
    assign o_empty = r_count == 2'd0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && o_valid;

    // Two-entry job queue between front and back.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ocx_back.sv
`default_nettype none

module ocx_back #(
    parameter int MAX_GENES = 64,
    localparam int PW = $clog2(MAX_GENES),
    localparam int CW = $clog2(MAX_GENES + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CW-1:0]      i_n_genes,
    input  wire ocx_pkg::t_store_wr i_wr,
    input  wire logic [PW-1:0]      i_wr_addr,
    input  wire logic               i_cmd_valid,
    input  wire ocx_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_idle,
    ocx_child_if.source             o_child
);

    localparam int GW = ocx_pkg::GENE_W;

    // Parent stores and the child buffer.
    logic [GW-1:0] r_first_mem  [MAX_GENES];
    logic [GW-1:0] r_second_mem [MAX_GENES];
    logic [GW-1:0] r_child_mem  [MAX_GENES];
    logic [GW-1:0] r_first_rd;
    logic [GW-1:0] r_second_rd;
    logic [GW-1:0] r_child_rd;

    ocx_pkg::t_back_state r_state;
    ocx_pkg::t_back_state n_state;

    logic [PW-1:0]                   r_k,         n_k;
    logic [PW-1:0]                   r_pos,       n_pos;
    logic [PW-1:0]                   r_donor,     n_donor;
    logic [CW-1:0]                   r_reads,     n_reads;
    logic [CW-1:0]                   r_fill_left, n_fill_left;
    logic [CW-1:0]                   r_seg_end,   n_seg_end;
    logic [ocx_pkg::MAP_DEPTH-1:0]   r_map,       n_map;
    logic                            r_out_valid, n_out_valid;
    logic [GW-1:0]                   r_out_gene,  n_out_gene;
    logic                            r_out_bad,   n_out_bad;
    logic                            r_out_last,  n_out_last;

    logic          cw_we;
    logic [PW-1:0] cw_addr;
    logic [GW-1:0] cw_data;
    logic          out_free;
    logic [CW-1:0] k_inc;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] donor_inc;
    logic [PW-1:0] pos_wrap;
    logic [PW-1:0] donor_wrap;
    logic [CW-1:0] cut_s;
    logic [CW-1:0] cut_e;
    logic [PW-1:0] fill_start;
    logic          seg_done;
    logic          out_last;
    logic          donor_kept;

    // Store writes come from the front; reads are registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_first_mem[i_wr_addr]  <= i_wr.first_gene;
            r_second_mem[i_wr_addr] <= i_wr.second_gene;
        end
        r_first_rd  <= r_first_mem[r_k];
        r_second_rd <= r_second_mem[r_donor];
    end

    always_ff @(posedge i_clk) begin
        if (cw_we) begin
            r_child_mem[cw_addr] <= cw_data;
        end
        r_child_rd <= r_child_mem[r_k];
    end

    // Position arithmetic, cyclic over the gene count.
    assign k_inc      = CW'(r_k) + CW'(1);
    assign pos_inc    = CW'(r_pos) + CW'(1);
    assign donor_inc  = CW'(r_donor) + CW'(1);
    assign pos_wrap   = (pos_inc >= i_n_genes) ? '0 : pos_inc[PW-1:0];
    assign donor_wrap = (donor_inc >= i_n_genes) ? '0 : donor_inc[PW-1:0];
    assign cut_s      = CW'(i_cmd.cut_start);
    assign cut_e      = CW'(i_cmd.cut_end);
    assign fill_start = (cut_e >= i_n_genes) ? '0 : cut_e[PW-1:0];
    assign seg_done   = k_inc == r_seg_end;
    assign out_last   = k_inc == i_n_genes;
    assign donor_kept = r_map[r_second_rd];
    assign out_free   = !r_out_valid || o_child.ready;

    assign o_idle    = r_state == ocx_pkg::BK_IDLE;
    assign o_cmd_pop = o_idle && i_cmd_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ocx_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.bad ? ocx_pkg::BK_ERR : ocx_pkg::BK_SEG_RD;
                end
            end
            ocx_pkg::BK_SEG_RD: begin
                n_state = ocx_pkg::BK_SEG_WR;
            end
            ocx_pkg::BK_SEG_WR: begin
                n_state = seg_done ? ocx_pkg::BK_FILL_POS : ocx_pkg::BK_SEG_RD;
            end
            ocx_pkg::BK_FILL_POS: begin
                if (r_fill_left == '0) begin
                    n_state = ocx_pkg::BK_OUT_RD;
                end else if (r_reads < i_n_genes) begin
                    n_state = ocx_pkg::BK_FILL_CHK;
                end
            end
            ocx_pkg::BK_FILL_CHK: begin
                n_state = ocx_pkg::BK_FILL_POS;
            end
            ocx_pkg::BK_OUT_RD: begin
                n_state = ocx_pkg::BK_OUT_SEND;
            end
            ocx_pkg::BK_OUT_SEND: begin
                if (out_free) begin
                    n_state = out_last ? ocx_pkg::BK_IDLE : ocx_pkg::BK_OUT_RD;
                end
            end
            ocx_pkg::BK_ERR: begin
                if (out_free) begin
                    n_state = ocx_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ocx_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs for each state.
    always_comb begin
        n_k         = r_k;
        n_pos       = r_pos;
        n_donor     = r_donor;
        n_reads     = r_reads;
        n_fill_left = r_fill_left;
        n_seg_end   = r_seg_end;
        n_map       = r_map;
        n_out_valid = r_out_valid && !o_child.ready;
        n_out_gene  = r_out_gene;
        n_out_bad   = r_out_bad;
        n_out_last  = r_out_last;
        cw_we       = 1'b0;
        cw_addr     = r_pos;
        cw_data     = '0;
        unique case (r_state)
            ocx_pkg::BK_IDLE: begin
                // Start of a good job: clear the segment map and set up the fill.
                if (i_cmd_valid && !i_cmd.bad) begin
                    n_map       = '0;
                    n_k         = cut_s[PW-1:0];
                    n_seg_end   = cut_e;
                    n_pos       = fill_start;
                    n_donor     = fill_start;
                    n_reads     = '0;
                    n_fill_left = i_n_genes - (cut_e - cut_s);
                end
            end
            ocx_pkg::BK_SEG_RD: begin
            end
            ocx_pkg::BK_SEG_WR: begin
                // Kept segment copies straight from the first parent.
                cw_we             = 1'b1;
                cw_addr           = r_k;
                cw_data           = r_first_rd;
                n_map[r_first_rd] = 1'b1;
                if (!seg_done) begin
                    n_k = k_inc[PW-1:0];
                end
            end
            ocx_pkg::BK_FILL_POS: begin
                if (r_fill_left == '0) begin
                    n_k = '0;
                end else if (r_reads >= i_n_genes) begin
                    // Donor reads ran out: the position gets a zero gene.
                    cw_we       = 1'b1;
                    n_pos       = pos_wrap;
                    n_fill_left = r_fill_left - CW'(1);
                end
            end
            ocx_pkg::BK_FILL_CHK: begin
                n_donor = donor_wrap;
                n_reads = r_reads + CW'(1);
                if (!donor_kept) begin
                    cw_we       = 1'b1;
                    cw_data     = r_second_rd;
                    n_pos       = pos_wrap;
                    n_fill_left = r_fill_left - CW'(1);
                end
            end
            ocx_pkg::BK_OUT_RD: begin
            end
            ocx_pkg::BK_OUT_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_gene  = r_child_rd;
                    n_out_bad   = 1'b0;
                    n_out_last  = out_last;
                    if (!out_last) begin
                        n_k = k_inc[PW-1:0];
                    end
                end
            end
            ocx_pkg::BK_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_gene  = '0;
                    n_out_bad   = 1'b1;
                    n_out_last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ocx_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_map       <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_donor     <= '0;
            r_reads     <= '0;
            r_fill_left <= '0;
            r_seg_end   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_map       <= n_map;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_donor     <= n_donor;
            r_reads     <= n_reads;
            r_fill_left <= n_fill_left;
            r_seg_end   <= n_seg_end;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_gene <= n_out_gene;
        r_out_bad  <= n_out_bad;
        r_out_last <= n_out_last;
    end

    assign o_child.valid      = r_out_valid;
    assign o_child.child_gene = r_out_gene;
    assign o_child.bad_cuts   = r_out_bad;
    assign o_child.last_gene  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/order_crossover_child.sv
`default_nettype none

// Order crossover (OX1) of two permutations of up to MAX_GENES genes. Parent
// gene pairs load at one beat per cycle; the beat with last_pair set carries
// the final pair and the cut points. The child keeps the first parent's genes
// in [cut_start, cut_end) and fills the other positions cyclically from
// cut_end with the second parent's genes, read cyclically from cut_end and
// skipping genes already kept. Bad cuts give one beat with bad_cuts set.
// After the final pair the back end copies the kept segment, fills the other
// positions from donor reads or with zero genes, and sends the child genes
// out; each segment copy, donor read and output step waits on the registered
// read of the parent stores and the child buffer. No new pair beat is taken
// while a job is queued or running; loading resumes once the last child beat
// has moved into the output register. gene_count is at APB byte address 0;
// values above MAX_GENES act as MAX_GENES.
module order_crossover_child #(
    parameter int MAX_GENES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ocx_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ocx_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ocx_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    ocx_pair_if.sink                              i_pair,
    ocx_child_if.source                           o_child
);

    localparam int PW = $clog2(MAX_GENES);
    localparam int CW = $clog2(MAX_GENES + 1);
    localparam int WW = (CW > ocx_pkg::CFG_W) ? CW : ocx_pkg::CFG_W;

    logic [ocx_pkg::CFG_W-1:0] r_gene_count;
    logic [CW-1:0]             n_genes;
    logic                      reg_sel;
    ocx_pkg::t_store_wr        store_wr;
    logic [PW-1:0]             store_addr;
    logic                      push;
    ocx_pkg::t_cmd             push_cmd;
    logic                      q_valid;
    logic                      q_empty;
    ocx_pkg::t_cmd             q_cmd;
    logic                      pop;
    logic                      back_idle;

    // Register file: a single count register.
    assign reg_sel = paddr[ocx_pkg::APB_ADDR_W-1] == ocx_pkg::REG_GENE_COUNT;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? ocx_pkg::APB_DATA_W'(r_gene_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gene_count <= ocx_pkg::GENE_COUNT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_gene_count <= pwdata[ocx_pkg::CFG_W-1:0];
        end
    end

    // Effective gene count, clamped to the store depth.
    assign n_genes = (WW'(r_gene_count) > WW'(MAX_GENES)) ? CW'(MAX_GENES)
                                                          : CW'(r_gene_count);

    ocx_front #(
        .MAX_GENES (MAX_GENES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n_genes     (n_genes),
        .i_back_idle   (back_idle),
        .i_queue_empty (q_empty),
        .i_pair        (i_pair),
        .o_wr          (store_wr),
        .o_wr_addr     (store_addr),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    ocx_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    ocx_back #(
        .MAX_GENES (MAX_GENES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_genes   (n_genes),
        .i_wr        (store_wr),
        .i_wr_addr   (store_addr),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_idle      (back_idle),
        .o_child     (o_child)
    );

endmodule

`default_nettype wire
